// ----- hw/rtl/cms_pkg.sv -----
package cms_pkg;

	// Sequencer states of the sketch engine.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_WAIT,
		ST_UPDATE,
		ST_NEXT,
		ST_OUT
	} state_t;

	// Request kinds carried in tuser.
	localparam logic REQ_ADD      = 1'b0;
	localparam logic REQ_ESTIMATE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [31:0] ROW_SALT = 32'h9E37_79B9;

	localparam int unsigned TDATA_W = 192;

	// Control from the sequencer to the remainder unit.
	typedef struct packed {
		logic start;
		logic [63:0] dividend;
	} mod_req_t;

endpackage

// ----- hw/rtl/cms_mod_unit.sv -----
module cms_mod_unit #(
	parameter int unsigned COL_W = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cms_pkg::mod_req_t      req,
	input  logic [COL_W-1:0]       divisor,
	output logic                   done,
	output logic [COL_W-1:0]       remainder
);

	// Restoring remainder, one dividend bit per cycle.
	logic [63:0]    dividend_q;
	logic [COL_W:0] rem_q;
	logic [6:0]     count_q;
	logic           busy_q;
	logic [COL_W+1:0] shifted;
	logic [COL_W+1:0] diff;

	assign shifted = {rem_q, dividend_q[63]};
	assign diff    = shifted - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= 7'd0;
			end else if (busy_q) begin
				count_q <= count_q + 7'd1;
				if (count_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath of the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[62:0], 1'b0};
			if (!diff[COL_W+1]) begin
				rem_q <= diff[COL_W:0];
			end else begin
				rem_q <= shifted[COL_W:0];
			end
		end
	end

	assign remainder = rem_q[COL_W-1:0];

endmodule

// ----- hw/rtl/count_min_sketch_unit.sv -----
// Count-min sketch engine over a table of 64-bit counters.
// Input transactions arrive on s_axis: tdata carries the two key hashes and
// the delta, tuser carries the request type and the key-present flag.
// A present-key add updates one counter per row in use and gives no result.
// An estimate request returns one result on m_axis: the minimum selected
// counter, or zero for an absent key or an all-ones minimum.
// Per row the column is found by a bit-serial remainder unit shared by all
// rows, followed by a read-modify-write of the counter memory; an item
// repeats this for each row in use, up to MAX_ROWS rows.
// One item is handled at a time; s_axis_tready is low while it is in work
// and while a result waits on m_axis, so a stalled receiver holds the block.
// After reset the counter memory is cleared one entry a cycle, all
// MAX_ROWS*MAX_COLUMNS entries, before the first input is taken.
// The user must make configuration writes (cfg_wr_en, cfg_index, cfg_data)
// only while idle; the block does not check. Reset: 1024 columns, 4 rows.
module count_min_sketch_unit #(
	parameter int unsigned MAX_ROWS    = 4,
	parameter int unsigned MAX_COLUMNS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [cms_pkg::TDATA_W-1:0] s_axis_tdata,  // key_hash_a, key_hash_b, delta
	input  logic [1:0]   s_axis_tuser,  // req_type, key_present
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // estimate
	input  logic         cfg_wr_en,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_data
);

	localparam int unsigned ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned COL_W   = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned CIDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned RCNT_W  = $clog2(MAX_ROWS + 1);

	cms_pkg::state_t state_q, state_d;

	logic [10:0] columns_q;
	logic [2:0]  rows_q;
	logic [COL_W-1:0]  eff_cols;
	logic [RCNT_W-1:0] eff_rows;

	logic        req_q;
	logic        present_q;
	logic [63:0] ha_q, hb_q, delta_q;
	logic [63:0] stride_q;
	logic [31:0] salt_q;
	logic [ROW_W-1:0] row_q;
	logic [63:0] best_q;
	logic [63:0] result_q;
	logic        out_valid_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;

	logic [63:0] mem [DEPTH];
	logic [63:0] rd_s1;

	cms_pkg::mod_req_t mreq;
	logic              mdone;
	logic [COL_W-1:0]  mrem;

	// Effective configuration, clamped to the legal range.
	always_comb begin
		if (columns_q == 11'd0) begin
			eff_cols = COL_W'(1);
		end else if (32'(columns_q) > MAX_COLUMNS) begin
			eff_cols = COL_W'(MAX_COLUMNS);
		end else begin
			eff_cols = COL_W'(columns_q);
		end
		if (rows_q == 3'd0) begin
			eff_rows = RCNT_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			eff_rows = RCNT_W'(MAX_ROWS);
		end else begin
			eff_rows = RCNT_W'(rows_q);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 11'd1024;
			rows_q    <= 3'd4;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cms_pkg::REG_COLUMNS: columns_q <= cfg_data;
				cms_pkg::REG_ROWS:    rows_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Row hash: base plus the row multiple of the stride plus the row salt,
	// the salt wrapping at 32 bits.
	assign mreq.start    = (state_q == cms_pkg::ST_HASH);
	assign mreq.dividend = ha_q + stride_q + {32'b0, salt_q};

	cms_mod_unit #(.COL_W(COL_W)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mreq),
		.divisor   (eff_cols),
		.done      (mdone),
		.remainder (mrem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cms_pkg::ST_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = cms_pkg::ST_IDLE;
			end
			cms_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser[1]) state_d = cms_pkg::ST_HASH;
					else if (s_axis_tuser[0] == cms_pkg::REQ_ESTIMATE)
						state_d = cms_pkg::ST_OUT;
					else state_d = cms_pkg::ST_IDLE;
				end
			end
			cms_pkg::ST_HASH:   state_d = cms_pkg::ST_MOD;
			cms_pkg::ST_MOD:    if (mdone) state_d = cms_pkg::ST_READ;
			cms_pkg::ST_READ:   state_d = cms_pkg::ST_WAIT;
			cms_pkg::ST_WAIT:   state_d = cms_pkg::ST_UPDATE;
			cms_pkg::ST_UPDATE: state_d = cms_pkg::ST_NEXT;
			cms_pkg::ST_NEXT: begin
				if (RCNT_W'(row_q) + RCNT_W'(1) >= eff_rows) begin
					state_d = (req_q == cms_pkg::REQ_ESTIMATE) ? cms_pkg::ST_OUT
						: cms_pkg::ST_IDLE;
				end else begin
					state_d = cms_pkg::ST_HASH;
				end
			end
			cms_pkg::ST_OUT:    if (!out_valid_q) state_d = cms_pkg::ST_IDLE;
			default:            state_d = cms_pkg::ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == cms_pkg::ST_IDLE) && !out_valid_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cms_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
		end else begin
			if (state_q == cms_pkg::ST_OUT && !out_valid_q) out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (state_q == cms_pkg::ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == cms_pkg::ST_IDLE) row_q <= '0;
			else if (state_q == cms_pkg::ST_NEXT) row_q <= row_q + ROW_W'(1);
			state_q <= (state_q == cms_pkg::ST_IDLE && !s_axis_tready)
				? state_q : state_d;
		end
	end

	// Item registers, hash steps, address and running minimum.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q     <= s_axis_tuser[0];
			present_q <= s_axis_tuser[1];
			ha_q      <= s_axis_tdata[63:0];
			hb_q      <= s_axis_tdata[127:64];
			delta_q   <= s_axis_tdata[191:128];
			stride_q  <= '0;
			salt_q    <= '0;
			best_q    <= '1;
		end
		if (state_q == cms_pkg::ST_HASH) begin
			stride_q <= stride_q + hb_q;
			salt_q   <= salt_q + cms_pkg::ROW_SALT;
		end
		if (state_q == cms_pkg::ST_READ) begin
			addr_q <= ADDR_W'(32'(row_q) * MAX_COLUMNS + 32'(mrem[CIDX_W-1:0]));
		end
		if (state_q == cms_pkg::ST_UPDATE && rd_s1 < best_q) best_q <= rd_s1;
		if (state_q == cms_pkg::ST_OUT && !out_valid_q) begin
			result_q <= (!present_q || best_q == '1) ? 64'd0 : best_q;
		end
	end

	// Counter memory, one port, cleared after reset.
	always_ff @(posedge clk) begin
		if (state_q == cms_pkg::ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == cms_pkg::ST_UPDATE && req_q == cms_pkg::REQ_ADD) begin
			mem[addr_q] <= rd_s1 + delta_q;
		end
		if (state_q == cms_pkg::ST_WAIT) rd_s1 <= mem[addr_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

endmodule

// ----- dv/cms_checker.sv -----
module cms_checker #(
	parameter int unsigned MAX_ROWS    = 4,
	parameter int unsigned MAX_COLUMNS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic         cfg_wr_en,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_data,
	output int           n_errors,
	output int           n_pending,
	output int           n_estimates,
	output int           n_adds
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] sketch_counters [MAX_ROWS*MAX_COLUMNS];
	logic [10:0] cols_reg;
	logic [2:0]  rows_reg;
	logic [63:0] estimates_due [$];

	// Column chosen by one row of the hash.
	function automatic int unsigned sketch_cell(int unsigned row, logic [63:0] ha,
			logic [63:0] hb, logic [63:0] cols);
		logic [31:0] salt;
		logic [63:0] h;
		salt = 32'(row * cms_pkg::ROW_SALT);
		h = ha + 64'(row) * hb + {32'b0, salt};
		return row * MAX_COLUMNS + int'(h % cols);
	endfunction

	// Predict each accepted transaction and compare each result transaction.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] ha, hb, delta, cols, best, v;
		int unsigned rows;
		if (!arst_n) begin
			foreach (sketch_counters[i]) sketch_counters[i] = '0;
			cols_reg = 11'd1024;
			rows_reg = 3'd4;
			estimates_due.delete();
			n_errors = 0;
			n_estimates = 0;
			n_adds = 0;
			n_pending = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == cms_pkg::REG_COLUMNS) cols_reg = cfg_data;
				else rows_reg = cfg_data[2:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ha = s_axis_tdata[63:0];
				hb = s_axis_tdata[127:64];
				delta = s_axis_tdata[191:128];
				cols = (cols_reg == 11'd0) ? 64'd1 :
					(32'(cols_reg) > MAX_COLUMNS) ? 64'(MAX_COLUMNS) : 64'(cols_reg);
				rows = (rows_reg == 3'd0) ? 1 :
					(32'(rows_reg) > MAX_ROWS) ? MAX_ROWS : 32'(rows_reg);
				if (s_axis_tuser[0] == cms_pkg::REQ_ADD) begin
					n_adds++;
					if (s_axis_tuser[1])
						for (int unsigned r = 0; r < rows; r++)
							sketch_counters[sketch_cell(r, ha, hb, cols)] += delta;
				end else if (!s_axis_tuser[1]) begin
					estimates_due.push_back('0);
				end else begin
					best = '1;
					for (int unsigned r = 0; r < rows; r++) begin
						v = sketch_counters[sketch_cell(r, ha, hb, cols)];
						if (v < best) best = v;
					end
					estimates_due.push_back((best == '1) ? 64'd0 : best);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_estimates++;
				if (estimates_due.size() == 0) begin
					$error("estimate: unexpected result %h", m_axis_tdata);
					n_errors++;
				end else begin
					v = estimates_due.pop_front();
					if (v !== m_axis_tdata) begin
						$error("estimate: expected %h, actual %h", v, m_axis_tdata);
						n_errors++;
					end
				end
			end
			n_pending = estimates_due.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1130;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         cfg_wr_en = 1'b0;
	logic         cfg_index = cms_pkg::REG_COLUMNS;
	logic [10:0]  cfg_data = '0;
	int           n_errors, n_pending, n_estimates, n_adds;
	int           cycle_count = 0;
	int           stall_left = 0;
	bit           quiet_phase = 1'b0;
	int           total_items = 0;

	// Keys recently added, reused for estimates so that hits are frequent.
	logic [63:0]  recent_a [$];
	logic [63:0]  recent_b [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	count_min_sketch_unit u_dut (.*);

	cms_checker u_chk (.*);

	// Receiver drops m_axis_tready in random bursts, except in the quiet phase.
	always @(negedge clk) begin
		if (quiet_phase) begin
			stall_left = 0;
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			if (stall_left == 0) m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'(v[9:0]);
			default: ;
		endcase
		return v;
	endfunction

	// Present one input transaction and wait for it to be taken; valid stays
	// high afterwards, so the next one follows without a gap unless a random gap is drawn.
	task automatic send_item(logic req, logic present, logic [63:0] ha,
			logic [63:0] hb, logic [63:0] delta);
		int gap;
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {delta, hb, ha};
		s_axis_tuser <= {present, req};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		total_items++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_item();
		logic [63:0] ha, hb;
		logic req;
		int k;
		req = 1'($urandom_range(0, 1));
		if (recent_a.size() != 0 && $urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, recent_a.size() - 1);
			ha = recent_a[k];
			hb = recent_b[k];
		end else begin
			ha = rand64();
			hb = rand64();
		end
		if (req == cms_pkg::REQ_ADD) begin
			recent_a.push_back(ha);
			recent_b.push_back(hb);
			if (recent_a.size() > 16) begin
				void'(recent_a.pop_front());
				void'(recent_b.pop_front());
			end
		end
		send_item(req, $urandom_range(0, 9) != 0, ha, hb, rand64());
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, absent keys, wrapping counters, all-ones minimum.
		send_item(cms_pkg::REQ_ESTIMATE, 1'b1, '0, '0, '0);
		send_item(cms_pkg::REQ_ADD, 1'b0, 64'd5, 64'd7, 64'd100);
		send_item(cms_pkg::REQ_ESTIMATE, 1'b0, 64'd5, 64'd7, '1);
		send_item(cms_pkg::REQ_ESTIMATE, 1'b1, 64'd5, 64'd7, '0);
		send_item(cms_pkg::REQ_ADD, 1'b1, '1, '1, '1);
		send_item(cms_pkg::REQ_ESTIMATE, 1'b1, '1, '1, '0);
		send_item(cms_pkg::REQ_ADD, 1'b1, '1, '1, 64'd3);
		send_item(cms_pkg::REQ_ESTIMATE, 1'b1, '1, '1, '0);
		send_item(cms_pkg::REQ_ADD, 1'b1, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000);
		send_item(cms_pkg::REQ_ESTIMATE, 1'b1, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, '0);
		wait_drained();

		// Phases over several settings, out-of-range values among them.
		for (int ph = 0; ph < 8; ph++) begin
			logic [10:0] cols;
			logic [10:0] rows;
			case (ph)
				0: begin cols = 11'd1; rows = 11'd1; end
				1: begin cols = 11'd0; rows = 11'd0; end
				2: begin cols = 11'd2047; rows = 11'd7; end
				3: begin cols = 11'd3; rows = 11'd2; end
				4: begin cols = 11'd1024; rows = 11'd4; end
				5: begin cols = 11'd1025; rows = 11'd5; end
				default: begin
					cols = 11'($urandom_range(1, 40));
					rows = 11'($urandom_range(1, 4));
				end
			endcase
			write_reg(cms_pkg::REG_COLUMNS, cols);
			write_reg(cms_pkg::REG_ROWS, rows);
			if (ph == 7) quiet_phase = 1'b1;
			for (int i = 0; i < N_RANDOM / 8; i++) random_item();
			wait_drained();
		end

		$display("Sent %0d items (%0d adds), checked %0d estimates", total_items, n_adds,
			n_estimates);
		$display("over eight column and row settings, including out-of-range values.");
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
